// ===== sv/pfgb_pkg.sv =====
// pfgb_pkg: request codes, font and icon tables for the glyph blitter
// no dependencies
`timescale 1ns / 1ps
package pfgb_pkg;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_GLYPH = 3'd1,
    REQ_BIG   = 3'd2,
    REQ_RECT  = 3'd3,
    REQ_ICON  = 3'd4,
    REQ_READ  = 3'd5
  } req_e;

  localparam int unsigned FirstCode = 32;
  localparam int unsigned LastCode  = 127;
  localparam int unsigned IconCols  = 24;
  localparam int unsigned IconPages = 4;
  localparam logic [7:0]  QuestionCode = 8'h3F;

  typedef struct packed {
    logic [2:0] req_type;
    logic [8:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] char_code;
    logic       invert;
    logic       pixel_on;
    logic [7:0] rect_width;
    logic [6:0] rect_height;
    logic [9:0] read_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
  } rsp_t;

  localparam logic [7:0] GLYPH_ROM [480] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h01,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h32, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h00,8'h7F,8'h10,8'h28,8'h44, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h08,8'h2A,8'h1C,8'h08, 8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [7:0] ICON_ROM [96] = '{
    8'h00,8'hE0,8'hF8,8'hFC,8'hFE,8'hFE,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFE,8'hFE,8'hFC,8'hF8,8'hE0,8'h00,8'h00,8'h00,
    8'h00,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,
    8'h00,8'h00,8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'h00,
    8'h00,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,
    8'h00,8'h00,8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'h00,
    8'h00,8'h07,8'h1F,8'h3F,8'h7F,8'h7F,8'h7F,8'h7F,8'h7F,8'h9F,8'hCF,8'hCF,
    8'hCF,8'h9F,8'h7F,8'h7F,8'h7F,8'h7F,8'h3F,8'h1F,8'h07,8'h00,8'h00,8'h00
  };

endpackage

// ===== sv/pfgb_req_if.sv =====
// pfgb_req_if: request channel with valid/ready handshake
// depends on pfgb_pkg
`timescale 1ns / 1ps
interface pfgb_req_if;
  logic            valid;
  logic            ready;
  pfgb_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pfgb_rsp_if.sv =====
// pfgb_rsp_if: result channel with valid/ready handshake
// depends on pfgb_pkg
`timescale 1ns / 1ps
interface pfgb_rsp_if;
  logic            valid;
  logic            ready;
  pfgb_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/page_framebuffer_glyph_blitter.sv =====
// page_framebuffer_glyph_blitter: page-organised framebuffer with glyph, rectangle,
// icon and read requests; depends on pfgb_pkg, pfgb_req_if, pfgb_rsp_if
`timescale 1ns / 1ps
// Each request is walked as a sequence of framebuffer bytes (one column of one page
// each). Every byte on screen is a read of the single-port store, then a write of the
// merged byte; a position off screen is skipped without a write. A glyph visits 6
// columns by 2 pages, a double glyph 10 columns by 3 pages, a rectangle of w by h
// pixels w columns by floor(h/8)+2 pages, the icon 24 columns by 5 pages. A read fetches
// one byte from the store, a clear walks every byte, one per cycle. After reset the store
// is cleared by that same walk, during which no request is accepted.
// The result register frees the engine, so the next request is taken while a result waits.
module page_framebuffer_glyph_blitter #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  pfgb_req_if.sink   req_i,
  pfgb_rsp_if.source rsp_o
);

  localparam int unsigned PageCount  = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned StoreBytes = SCREEN_WIDTH * PageCount;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned ColW       = $clog2(SCREEN_WIDTH);
  localparam int unsigned PageW      = (PageCount > 1) ? $clog2(PageCount) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_MOD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  pfgb_pkg::req_t r_q;
  logic [7:0] mem [StoreBytes];
  logic [7:0] rdata_q;
  logic [AddrW:0] clr_q, clr_d;
  // walk: column offset 0..254 and page offset 0..16 relative to the object
  logic [7:0] dc_q, dc_d;
  logic [4:0] dp_q, dp_d;
  logic [7:0] ncol_q;
  logic [4:0] npage_q;
  logic [7:0] code_q;
  logic       is_rd_q;
  logic       boot_q;
  logic       rsp_valid_q;
  logic [7:0] rsp_data_q;

  logic signed [10:0] col_s;
  logic signed [10:0] page_s;
  logic               in_scr;
  logic [AddrW-1:0]   addr;
  logic [7:0]         new_byte;
  logic               last_pos;

  // object size in columns and pages that may be touched
  logic [7:0] ncol_c;
  logic [4:0] npage_c;
  logic [7:0] code_c;
  always_comb begin
    code_c = req_i.data.char_code;
    if (req_i.data.req_type == pfgb_pkg::REQ_GLYPH &&
        (req_i.data.char_code < 8'(pfgb_pkg::FirstCode) ||
         req_i.data.char_code > 8'(pfgb_pkg::LastCode))) begin
      code_c = pfgb_pkg::QuestionCode;
    end
    case (req_i.data.req_type)
      pfgb_pkg::REQ_GLYPH: begin ncol_c = 8'd6; npage_c = 5'd2; end
      pfgb_pkg::REQ_BIG:   begin ncol_c = 8'd10; npage_c = 5'd3; end
      pfgb_pkg::REQ_RECT:  begin
        ncol_c  = req_i.data.rect_width;
        npage_c = 5'(req_i.data.rect_height[6:3]) + 5'd2;
      end
      pfgb_pkg::REQ_ICON:  begin ncol_c = 8'd24; npage_c = 5'd5; end
      default:             begin ncol_c = 8'd0; npage_c = 5'd0; end
    endcase
  end

  always_comb begin
    col_s  = 11'($signed(r_q.x_pos)) + $signed({3'b000, dc_q});
    page_s = 11'($signed(r_q.y_pos) >>> 3) + $signed({6'b0, dp_q});
    in_scr = col_s >= 0 && col_s < $signed(11'(SCREEN_WIDTH)) &&
             page_s >= 0 && page_s < $signed(11'(PageCount));
    addr   = AddrW'(page_s[PageW-1:0] * SCREEN_WIDTH) + AddrW'(col_s[ColW-1:0]);
    last_pos = (dc_q == ncol_q - 8'd1) && (dp_q == npage_q - 5'd1);
  end

  // pixel merge for one byte
  always_comb begin
    logic signed [10:0] ry;
    logic [7:0]         bits;
    logic [3:0]         gc;
    logic               lit;
    logic               hit;
    logic [9:0]         gidx;
    new_byte = rdata_q;
    for (int b = 0; b < 8; b++) begin
      ry   = (page_s <<< 3) + 11'(b) - 11'($signed(r_q.y_pos));
      hit  = 1'b0;
      lit  = 1'b0;
      gc   = 4'd0;
      bits = 8'd0;
      gidx = 10'd0;
      case (r_q.req_type)
        pfgb_pkg::REQ_GLYPH: begin
          gidx = 10'((code_q - 8'(pfgb_pkg::FirstCode)) * 5) + 10'(dc_q[2:0]);
          bits = (dc_q < 8'd5) ? pfgb_pkg::GLYPH_ROM[gidx[8:0]] : 8'd0;
          hit  = ry >= 0 && ry < 7;
          lit  = bits[ry[2:0]] ^ r_q.invert;
        end
        pfgb_pkg::REQ_BIG: begin
          gc   = dc_q[4:1];
          gidx = 10'((code_q - 8'(pfgb_pkg::FirstCode)) * 5) + 10'(gc);
          bits = pfgb_pkg::GLYPH_ROM[gidx[8:0]];
          hit  = ry >= 0 && ry < 14;
          lit  = bits[ry[3:1]] ^ r_q.invert;
        end
        pfgb_pkg::REQ_RECT: begin
          hit = ry >= 0 && ry < $signed({4'b0, r_q.rect_height});
          lit = r_q.pixel_on;
        end
        pfgb_pkg::REQ_ICON: begin
          hit  = ry >= 0 && ry < 32;
          gidx = 10'(ry[4:3]) * 10'(pfgb_pkg::IconCols) + 10'(dc_q[4:0]);
          lit  = pfgb_pkg::ICON_ROM[gidx[6:0]][ry[2:0]];
          hit  = hit && lit;
        end
        default: hit = 1'b0;
      endcase
      if (hit) new_byte[b] = lit;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    dc_d    = dc_q;
    dp_d    = dp_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW + 1)'(StoreBytes - 1)) state_d = ST_DONE;
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          dc_d = 8'd0;
          dp_d = 5'd0;
          clr_d = '0;
          case (req_i.data.req_type)
            pfgb_pkg::REQ_CLEAR: state_d = ST_CLEAR;
            pfgb_pkg::REQ_READ:  state_d = ST_READ;
            default: begin
              if (ncol_c == 8'd0 || npage_c == 5'd0 ||
                  (req_i.data.req_type == pfgb_pkg::REQ_BIG &&
                   (req_i.data.char_code < 8'(pfgb_pkg::FirstCode) ||
                    req_i.data.char_code > 8'(pfgb_pkg::LastCode)))) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_READ;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        if (is_rd_q) state_d = ST_DONE;
        else if (!in_scr) begin
          if (last_pos) state_d = ST_DONE;
          else if (dp_q == npage_q - 5'd1) begin dp_d = 5'd0; dc_d = dc_q + 8'd1; end
          else dp_d = dp_q + 5'd1;
        end else state_d = ST_MOD;
      end
      ST_MOD: begin
        if (last_pos) state_d = ST_DONE;
        else begin
          state_d = ST_READ;
          if (dp_q == npage_q - 5'd1) begin dp_d = 5'd0; dc_d = dc_q + 8'd1; end
          else dp_d = dp_q + 5'd1;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) mem[clr_q[AddrW-1:0]] <= 8'd0;
    else if (state_q == ST_MOD) mem[addr] <= new_byte;
    if (state_q == ST_READ) begin
      if (is_rd_q) rdata_q <= (32'(r_q.read_index) < StoreBytes) ?
                               mem[AddrW'(r_q.read_index)] : 8'd0;
      else rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      r_q     <= req_i.data;
      ncol_q  <= ncol_c;
      npage_q <= npage_c;
      code_q  <= code_c;
      is_rd_q <= req_i.data.req_type == pfgb_pkg::REQ_READ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dc_q        <= 8'd0;
      dp_q        <= 5'd0;
      boot_q      <= 1'b1;
      rsp_valid_q <= 1'b0;
      rsp_data_q  <= 8'd0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dc_q    <= dc_d;
      dp_q    <= dp_d;
      // the clear after reset answers no request
      if (state_q == ST_DONE) boot_q <= 1'b0;
      if (state_q == ST_DONE && (!rsp_valid_q || rsp_o.ready) && !boot_q) begin
        rsp_valid_q <= 1'b1;
        rsp_data_q  <= is_rd_q ? rdata_q : 8'd0;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.data.read_data = rsp_data_q;

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !req_i.ready) else $error("request taken during clear");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_data_q))
    else $error("result dropped");
  a_write_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MOD |-> in_scr) else $error("write off screen");
`endif

endmodule
